@@ hw/rtl/mrc_pkg.sv @@
package mrc_pkg;

	localparam int unsigned RADIX_REGS = 4;
	localparam int unsigned DEF_MAX_DIMS = 4;
	localparam int unsigned IDX_W = 32;
	localparam int unsigned RADIX_W = 9;
	localparam int unsigned DIGIT_W = 8;
	localparam int unsigned POS_W = 2;
	localparam int unsigned DIMS_W = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 9;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DIMS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIX_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIX_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIX_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RADIX_3 = 3'd4;

	// input actions
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	localparam logic [RADIX_W-1:0] RADIX_MAX = 9'd256;

	typedef struct packed {
		logic start;
		logic [IDX_W-1:0] dividend;
		logic [RADIX_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [IDX_W-1:0] quot;
		logic [DIGIT_W-1:0] rem;
	} div_rsp_t;

	// clamp a radix register to 1..256
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] v;
		v = r;
		if (v == '0) v = 9'd1;
		if (v > RADIX_MAX) v = RADIX_MAX;
		return v;
	endfunction

endpackage

@@ hw/rtl/mrc_if.sv @@
interface mrc_item_if import mrc_pkg::*; ();
	logic valid;
	logic ready;
	logic action;
	logic [IDX_W-1:0] flat_index;

	modport source (output valid, action, flat_index, input ready);
	modport sink (input valid, action, flat_index, output ready);
endinterface

interface mrc_result_if import mrc_pkg::*; ();
	logic valid;
	logic ready;
	logic [POS_W-1:0] digit_position;
	logic [DIGIT_W-1:0] digit_value;
	logic [IDX_W-1:0] composed_index;
	logic exhausted;
	logic last;

	modport source (output valid, digit_position, digit_value, composed_index, exhausted, last,
		input ready);
	modport sink (input valid, digit_position, digit_value, composed_index, exhausted, last,
		output ready);
endinterface

@@ hw/rtl/mrc_divider.sv @@
module mrc_divider import mrc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);

	localparam int unsigned CNT_W = $clog2(IDX_W + 1);
	localparam logic [CNT_W-1:0] STEPS = CNT_W'(IDX_W);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] shreg_q;
	logic [RADIX_W-1:0] rem_q;
	logic [RADIX_W-1:0] div_q;
	logic [RADIX_W-1:0] trial;
	logic fits;

	// shift the next dividend bit into the partial remainder and try one subtract
	assign trial = {rem_q[RADIX_W-2:0], shreg_q[IDX_W-1]};
	assign fits = trial >= div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEPS - 1'b1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			shreg_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			shreg_q <= {shreg_q[IDX_W-2:0], fits};
			rem_q <= fits ? trial - div_q : trial;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = shreg_q;
	assign rsp.rem = rem_q[DIGIT_W-1:0];

endmodule

@@ hw/rtl/mixed_radix_index_counter.sv @@
// Load: one 32-step pass of the shared divider per digit position in use,
//   then the index is composed position by position.
// Advance: positions are stepped until the carry dies, then the index is composed again.
// Results then leave one per cycle while the sink takes them; no new item is taken meanwhile.
// Reset (arst_n low, asynchronous): digits zero, dims_in_use 2, every radix 2, block idle.
module mixed_radix_index_counter import mrc_pkg::*; #(
	parameter int unsigned MAX_DIMS = DEF_MAX_DIMS
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	mrc_item_if.sink item,
	mrc_result_if.source result
);

	localparam int unsigned NUM_POS = (MAX_DIMS < RADIX_REGS) ? MAX_DIMS : RADIX_REGS;
	localparam int unsigned PIDX_W = (NUM_POS > 1) ? $clog2(NUM_POS) : 1;
	localparam logic [DIMS_W-1:0] DIMS_CAP = DIMS_W'(NUM_POS);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DIV_GO = 6'b000010,
		S_DIV_WAIT = 6'b000100,
		S_ADV = 6'b001000,
		S_COMP = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	state_t state_q;
	logic [DIMS_W-1:0] dims_q;
	logic [RADIX_W-1:0] radix_q [RADIX_REGS];
	logic [DIGIT_W-1:0] digit_q [NUM_POS];
	logic [POS_W-1:0] pos_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] acc_q;
	logic exhausted_q;

	logic [DIMS_W-1:0] dims_eff;
	logic [POS_W-1:0] last_pos;
	logic [RADIX_W-1:0] cur_radix;
	logic [DIGIT_W-1:0] cur_digit;
	logic [RADIX_W-1:0] digit_inc;
	logic [IDX_W+RADIX_W-1:0] prod;
	logic [IDX_W-1:0] acc_next;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// clamp the dimension count to 1..NUM_POS
	always_comb begin
		dims_eff = dims_q;
		if (dims_eff == '0) dims_eff = 3'd1;
		if (dims_eff > DIMS_CAP) dims_eff = DIMS_CAP;
	end

	assign last_pos = POS_W'(dims_eff - 3'd1);
	assign cur_radix = eff_radix(radix_q[pos_q]);
	assign cur_digit = digit_q[pos_q[PIDX_W-1:0]];
	assign digit_inc = {1'b0, cur_digit} + 9'd1;
	assign prod = acc_q * cur_radix;
	assign acc_next = prod[IDX_W-1:0] + IDX_W'(cur_digit);

	assign div_req.start = (state_q == S_DIV_GO);
	assign div_req.dividend = idx_q;
	assign div_req.divisor = cur_radix;

	mrc_divider u_div (
		.clk (clk),
		.arst_n (arst_n),
		.req (div_req),
		.rsp (div_rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= 3'd2;
			for (int i = 0; i < RADIX_REGS; i++) radix_q[i] <= 9'd2;
		end else if (cfg_we) begin
			if (cfg_index == REG_DIMS) begin
				dims_q <= cfg_wdata[DIMS_W-1:0];
			end else if (cfg_index >= REG_RADIX_0 && cfg_index <= REG_RADIX_3) begin
				radix_q[POS_W'(cfg_index - REG_RADIX_0)] <= cfg_wdata;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q <= '0;
			exhausted_q <= 1'b0;
			for (int i = 0; i < NUM_POS; i++) digit_q[i] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						pos_q <= last_pos;
						exhausted_q <= 1'b0;
						state_q <= (item.action == ACT_LOAD) ? S_DIV_GO : S_ADV;
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					// store the remainder, move up one position
					if (div_rsp.done) begin
						digit_q[pos_q[PIDX_W-1:0]] <= div_rsp.rem;
						if (pos_q == '0) begin
							state_q <= S_COMP;
						end else begin
							pos_q <= pos_q - 1'b1;
							state_q <= S_DIV_GO;
						end
					end
				end
				S_ADV: begin
					// step one position; stop when the carry dies
					if (digit_inc < cur_radix) begin
						digit_q[pos_q[PIDX_W-1:0]] <= digit_inc[DIGIT_W-1:0];
						pos_q <= '0;
						state_q <= S_COMP;
					end else begin
						digit_q[pos_q[PIDX_W-1:0]] <= '0;
						if (pos_q == '0) begin
							exhausted_q <= 1'b1;
							state_q <= S_COMP;
						end else begin
							pos_q <= pos_q - 1'b1;
						end
					end
				end
				S_COMP: begin
					if (pos_q == last_pos) begin
						pos_q <= '0;
						state_q <= S_EMIT;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (result.ready) begin
						if (pos_q == last_pos) begin
							pos_q <= '0;
							state_q <= S_IDLE;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// load index and composition accumulator
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item.valid) begin
			idx_q <= item.flat_index;
		end else if (state_q == S_DIV_WAIT && div_rsp.done) begin
			idx_q <= div_rsp.quot;
		end
		if (state_q == S_COMP) begin
			acc_q <= (pos_q == '0) ? IDX_W'(cur_digit) : acc_next;
		end
	end

	assign item.ready = (state_q == S_IDLE);

	assign result.valid = (state_q == S_EMIT);
	assign result.digit_position = pos_q;
	assign result.digit_value = cur_digit;
	assign result.composed_index = acc_q;
	assign result.exhausted = exhausted_q;
	assign result.last = (pos_q == last_pos);

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !result.valid && !div_rsp.busy)
		else $error("item taken while results or division pending");

	a_first_pos: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> result.digit_position == '0)
		else $error("result burst does not start at position zero");

	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.last |=> result.valid)
		else $error("result burst ended before last digit");

	a_exh_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.exhausted |-> result.composed_index == '0
			&& result.digit_value == '0)
		else $error("exhausted with nonzero digits");
`endif

endmodule
